// ===== hdl/ftb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ftb_pkg;

   localparam int NUM_VIEWS  = 16;
   localparam int MAX_POINTS = 4096;
   localparam int MAX_TRACKS = 16384;

   localparam int VIEW_W  = $clog2(NUM_VIEWS);
   localparam int POINT_W = $clog2(MAX_POINTS);
   localparam int KEY_W   = VIEW_W + POINT_W;
   localparam int KEYS    = NUM_VIEWS * MAX_POINTS;
   localparam int TRACK_W = $clog2(MAX_TRACKS);
   // keypoint table entry: 0 = unassigned, else track id + 1
   localparam int ENTRY_W = TRACK_W + 1;
   localparam int COUNT_W = TRACK_W + 1;

   localparam logic [12:0] MIN_MATCHES_RESET = 13'd8;

   localparam logic [2:0] STATUS_SKIPPED   = 3'd0;
   localparam logic [2:0] STATUS_NEW       = 3'd1;
   localparam logic [2:0] STATUS_APPENDED  = 3'd2;
   localparam logic [2:0] STATUS_NO_CHANGE = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   typedef struct packed {
      logic [3:0]         image_a;
      logic [11:0]        point_a;
      logic signed [15:0] x_a;
      logic signed [15:0] y_a;
      logic [3:0]         image_b;
      logic [11:0]        point_b;
      logic signed [15:0] x_b;
      logic signed [15:0] y_b;
      logic [12:0]        pair_match_count;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [13:0]        track_id;
      logic [3:0]         member_image;
      logic [11:0]        member_point;
      logic signed [15:0] member_x;
      logic signed [15:0] member_y;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [KEY_W-1:0]   wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [KEY_W-1:0]   rd_addr;
   } kp_port_type;

   typedef struct packed {
      logic                 wr_en;
      logic [TRACK_W-1:0]   wr_addr;
      logic [NUM_VIEWS-1:0] wr_data;
      logic                 rd_en;
      logic [TRACK_W-1:0]   rd_addr;
   } vw_port_type;

endpackage

`default_nettype wire

// ===== hdl/ftb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ftb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ftb_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ftb_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [12:0]                   min_matches,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire ftb_pkg::req_type              req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ftb_pkg::rsp_type                   rsp_payload,
   output ftb_pkg::kp_port_type               kp_port,
   input  wire logic [ftb_pkg::ENTRY_W-1:0]   kp_rd_data,
   output ftb_pkg::vw_port_type               vw_port,
   input  wire logic [ftb_pkg::NUM_VIEWS-1:0] vw_rd_data
);

   import ftb_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_RD_B   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_WR_B   = 3'd4;
   localparam logic [2:0] S_VIEWS  = 3'd5;
   localparam logic [2:0] S_EMIT2  = 3'd6;
   localparam logic [2:0] S_EMIT1  = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [KEY_W-1:0]   clr_ff, clr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   req_type            item_ff, item_in;
   logic [ENTRY_W-1:0] ta_ff, ta_in;
   logic               selb_ff, selb_in;
   logic [TRACK_W-1:0] tid_ff, tid_in;
   rsp_type            res0_ff, res0_in;
   rsp_type            res1_ff, res1_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_load;
   logic               slot_free;

   function automatic logic [KEY_W-1:0] key_of(logic [3:0] img, logic [11:0] pt);
      return {VIEW_W'(img), POINT_W'(pt)};
   endfunction

   function automatic rsp_type make_rsp(logic [2:0] status, logic [TRACK_W-1:0] tid,
                                        logic [3:0] img, logic [11:0] pt,
                                        logic [15:0] x, logic [15:0] y, logic last);
      rsp_type r;
      r.status       = status;
      r.track_id     = 14'(tid);
      r.member_image = img;
      r.member_point = pt;
      r.member_x     = x;
      r.member_y     = y;
      r.last         = last;
      return r;
   endfunction

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic               skip;
      logic [ENTRY_W-1:0] tb;
      logic [ENTRY_W-1:0] t_ent;
      logic [ENTRY_W-1:0] tid_ent;
      logic [3:0]         img;
      logic [11:0]        pt;
      logic [15:0]        mx;
      logic [15:0]        my;
      logic [NUM_VIEWS-1:0] bit_sel;

      state_in = state_ff;
      clr_in   = clr_ff;
      count_in = count_ff;
      item_in  = item_ff;
      ta_in    = ta_ff;
      selb_in  = selb_ff;
      tid_in   = tid_ff;
      res0_in  = res0_ff;
      res1_in  = res1_ff;
      kp_port  = '0;
      vw_port  = '0;
      rsp_load = 1'b0;
      req_stall = 1'b1;

      skip = (req_payload.pair_match_count <= min_matches) ||
             (int'(req_payload.image_a) >= NUM_VIEWS) ||
             (int'(req_payload.image_b) >= NUM_VIEWS) ||
             (int'(req_payload.point_a) >= MAX_POINTS) ||
             (int'(req_payload.point_b) >= MAX_POINTS);
      tb      = kp_rd_data;
      t_ent   = ((ta_ff != '0) ? ta_ff : tb) - ENTRY_W'(1);
      tid_ent = ENTRY_W'(tid_ff) + ENTRY_W'(1);
      img     = selb_ff ? item_ff.image_b : item_ff.image_a;
      pt      = selb_ff ? item_ff.point_b : item_ff.point_a;
      mx      = selb_ff ? item_ff.x_b : item_ff.x_a;
      my      = selb_ff ? item_ff.y_b : item_ff.y_a;
      bit_sel = NUM_VIEWS'(1) << img;

      unique case (state_ff)
         S_CLEAR: begin
            kp_port.wr_en   = 1'b1;
            kp_port.wr_addr = clr_ff;
            kp_port.wr_data = '0;
            clr_in = clr_ff + KEY_W'(1);
            if (clr_ff == KEY_W'(KEYS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_in = req_payload;
               if (skip) begin
                  res0_in  = make_rsp(STATUS_SKIPPED, '0, '0, '0, '0, '0, 1'b1);
                  state_in = S_EMIT1;
               end else begin
                  kp_port.rd_en   = 1'b1;
                  kp_port.rd_addr = key_of(req_payload.image_a, req_payload.point_a);
                  state_in = S_RD_B;
               end
            end
         end
         S_RD_B: begin
            kp_port.rd_en   = 1'b1;
            kp_port.rd_addr = key_of(item_ff.image_b, item_ff.point_b);
            ta_in    = kp_rd_data;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (ta_ff == '0 && tb == '0) begin
               if (count_ff == COUNT_W'(MAX_TRACKS)) begin
                  res0_in  = make_rsp(STATUS_FULL, '0, '0, '0, '0, '0, 1'b1);
                  state_in = S_EMIT1;
               end else begin
                  tid_in          = count_ff[TRACK_W-1:0];
                  vw_port.wr_en   = 1'b1;
                  vw_port.wr_addr = count_ff[TRACK_W-1:0];
                  vw_port.wr_data = (NUM_VIEWS'(1) << item_ff.image_a) |
                                    (NUM_VIEWS'(1) << item_ff.image_b);
                  kp_port.wr_en   = 1'b1;
                  kp_port.wr_addr = key_of(item_ff.image_a, item_ff.point_a);
                  kp_port.wr_data = ENTRY_W'(count_ff + COUNT_W'(1));
                  count_in = count_ff + COUNT_W'(1);
                  res0_in  = make_rsp(STATUS_NEW, count_ff[TRACK_W-1:0], item_ff.image_a,
                                      item_ff.point_a, item_ff.x_a, item_ff.y_a, 1'b0);
                  res1_in  = make_rsp(STATUS_NEW, count_ff[TRACK_W-1:0], item_ff.image_b,
                                      item_ff.point_b, item_ff.x_b, item_ff.y_b, 1'b1);
                  state_in = S_WR_B;
               end
            end else if (ta_ff != '0 && tb != '0) begin
               res0_in  = make_rsp(STATUS_NO_CHANGE, t_ent[TRACK_W-1:0],
                                   '0, '0, '0, '0, 1'b1);
               state_in = S_EMIT1;
            end else begin
               // one side is tracked: fetch that track's image mask
               selb_in         = (ta_ff != '0);
               tid_in          = t_ent[TRACK_W-1:0];
               vw_port.rd_en   = 1'b1;
               vw_port.rd_addr = t_ent[TRACK_W-1:0];
               state_in = S_VIEWS;
            end
         end
         S_WR_B: begin
            kp_port.wr_en   = 1'b1;
            kp_port.wr_addr = key_of(item_ff.image_b, item_ff.point_b);
            kp_port.wr_data = tid_ent;
            state_in = S_EMIT2;
         end
         S_VIEWS: begin
            if ((vw_rd_data & bit_sel) != '0) begin
               res0_in = make_rsp(STATUS_NO_CHANGE, tid_ff, '0, '0, '0, '0, 1'b1);
            end else begin
               vw_port.wr_en   = 1'b1;
               vw_port.wr_addr = tid_ff;
               vw_port.wr_data = vw_rd_data | bit_sel;
               kp_port.wr_en   = 1'b1;
               kp_port.wr_addr = key_of(img, pt);
               kp_port.wr_data = tid_ent;
               res0_in = make_rsp(STATUS_APPENDED, tid_ff, img, pt, mx, my, 1'b1);
            end
            state_in = S_EMIT1;
         end
         S_EMIT2: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               res0_in  = res1_ff;
               state_in = S_EMIT1;
            end
         end
         S_EMIT1: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = rsp_load ? res0_ff : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ta_ff       <= ta_in;
      selb_ff     <= selb_in;
      tid_ff      <= tid_in;
      res0_ff     <= res0_in;
      res1_ff     <= res1_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_TRACKS))
      else $error("track count beyond store size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |->
         (count_ff == $past(count_ff) + COUNT_W'(1) && $past(state_ff) == S_DECIDE))
      else $error("track count moved outside allocation");

   a_new_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res0_ff.status == STATUS_NEW && !res0_ff.last) |=>
         (state_ff == S_EMIT1 && res0_ff.status == STATUS_NEW && res0_ff.last))
      else $error("new track first member not followed by second");

endmodule

`default_nettype wire

// ===== hdl/feature_track_builder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  ftb_pkg::req_type (one match)
// rsp_      out        rsp_valid / rsp_stall  ftb_pkg::rsp_type (one or two per match)
// csr_      in         csr_write_enable       min_matches, 13 bit
//
// One match at a time; the keypoint lookups for its two points share the table's
// single read port. After reset the keypoint table is cleared one entry a cycle
// (65536 entries); req_stall stays high until it completes. CSR writes are taken
// at any time. A stalled result holds in the output register; the next match is
// taken meanwhile.

module feature_track_builder_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [12:0]      csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ftb_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ftb_pkg::rsp_type      rsp_payload
);

   import ftb_pkg::*;

   logic [12:0]          min_matches_ff, min_matches_in;
   kp_port_type          kp_port;
   vw_port_type          vw_port;
   logic [ENTRY_W-1:0]   kp_rd_data;
   logic [NUM_VIEWS-1:0] vw_rd_data;

   assign min_matches_in = csr_write_enable ? csr_write_data : min_matches_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_matches_ff <= MIN_MATCHES_RESET;
      end else begin
         min_matches_ff <= min_matches_in;
      end
   end

   ftb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEYS)
   ) u_kp_ram (
      .clock   (clock),
      .wr_en   (kp_port.wr_en),
      .wr_addr (kp_port.wr_addr),
      .wr_data (kp_port.wr_data),
      .rd_en   (kp_port.rd_en),
      .rd_addr (kp_port.rd_addr),
      .rd_data (kp_rd_data)
   );

   ftb_ram #(
      .WIDTH (NUM_VIEWS),
      .DEPTH (MAX_TRACKS)
   ) u_vw_ram (
      .clock   (clock),
      .wr_en   (vw_port.wr_en),
      .wr_addr (vw_port.wr_addr),
      .wr_data (vw_port.wr_data),
      .rd_en   (vw_port.rd_en),
      .rd_addr (vw_port.rd_addr),
      .rd_data (vw_rd_data)
   );

   ftb_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .min_matches (min_matches_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .kp_port     (kp_port),
      .kp_rd_data  (kp_rd_data),
      .vw_port     (vw_port),
      .vw_rd_data  (vw_rd_data)
   );

endmodule

`default_nettype wire
